>>> hw/rtl/concentric_square_to_disk_map_assert.svh
// assertion macros for the concentric square-to-disk map
// used by the top level; expects clk and rst in scope
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_ASSERT_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSDM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSDM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CSDM_CHECK(lbl, prop, msg)
`define CSDM_NEVER(lbl, expr, msg)
`endif
`endif

>>> hw/rtl/csdm_pkg.sv
// shared types, constants and the arctangent table for the disk map
// no dependencies
package csdm_pkg;

  localparam int CSDM_COORD_BITS = 16;
  localparam int CSDM_ANGLE_ITERATIONS = 16;
  localparam int CSDM_DIV_STEPS = 30;
  localparam int CSDM_OUT_MAX = 32767;
  localparam logic signed [32:0] CSDM_GAIN_INV = 33'sh026DD3B6A;
  localparam logic signed [31:0] CSDM_PI4 = 32'sh3243F6A8;

  typedef struct packed {
    logic [15:0] square_x;
    logic [15:0] square_y;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
  } point_t;

  // one step of the restoring quotient chain plus what rides along
  typedef struct packed {
    logic [17:0]        rem;
    logic [16:0]        den;
    logic [30:0]        quo;
    logic               neg;
    logic [1:0]         sector;
    logic signed [17:0] radius;
  } div_state_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
    logic signed [17:0] radius;
  } cordic_state_t;

  function automatic logic signed [32:0] csdm_atan(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF;  20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF;  23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F;  26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004;  29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

>>> hw/rtl/csdm_div_cell.sv
// one quotient bit of the restoring divider chain
// depends on csdm_pkg
module csdm_div_cell import csdm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  input  div_state_t state_in,
  output logic       valid_out,
  output div_state_t state_out
);

  logic [17:0] rem2;
  logic        ge;
  div_state_t  state_next;

  assign rem2 = {state_in.rem[16:0], 1'b0};
  assign ge   = rem2 >= {1'b0, state_in.den};

  always_comb begin
    state_next     = state_in;
    state_next.rem = ge ? rem2 - {1'b0, state_in.den} : rem2;
    state_next.quo = {state_in.quo[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    state_out <= state_next;
  end

endmodule

>>> hw/rtl/csdm_cordic_cell.sv
// one rotation-mode cordic step with a fixed shift
// depends on csdm_pkg
module csdm_cordic_cell import csdm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  cordic_state_t state_in,
  output logic          valid_out,
  output cordic_state_t state_out
);

  localparam logic signed [32:0] Angle = csdm_atan(STEP);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  cordic_state_t      state_next;

  assign dx = state_in.y >>> STEP;
  assign dy = state_in.x >>> STEP;

  always_comb begin
    state_next = state_in;
    if (!state_in.z[32]) begin
      state_next.x = state_in.x - dx;
      state_next.y = state_in.y + dy;
      state_next.z = state_in.z - Angle;
    end else begin
      state_next.x = state_in.x + dx;
      state_next.y = state_in.y - dy;
      state_next.z = state_in.z + Angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    state_out <= state_next;
  end

endmodule

>>> hw/rtl/concentric_square_to_disk_map.sv
// concentric square-to-disk map: one point of the unit square per cycle
// to a point of the unit disk; depends on csdm_pkg, csdm_div_cell,
// csdm_cordic_cell and concentric_square_to_disk_map_assert.svh
//
// a fully pipelined block: busy is always low and a new item may be started
// every cycle. an item runs through setup, the 30-cell quotient chain,
// angle, radians, one cordic cell per iteration, rotate, product and out.
// the result shows on point for exactly one cycle with done high; the
// receiver cannot stall it, so it must take every result.
module concentric_square_to_disk_map import csdm_pkg::*; #(
  parameter int ANGLE_ITERATIONS = CSDM_ANGLE_ITERATIONS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sample_t sample,
  output logic    busy,
  output logic    done,
  output point_t  point
);

  `include "concentric_square_to_disk_map_assert.svh"

  // setup + quotient cells + angle + scale + cordic + rotate + product + out
  localparam int Latency = CSDM_DIV_STEPS + ANGLE_ITERATIONS + 6;

  assign busy = 1'b0;

  // ---- setup: scale to [-1,1), pick the sector, first quotient bit
  logic signed [17:0] a;
  logic signed [17:0] b;
  logic signed [18:0] sum_ab;
  logic               upper;
  logic               a_gt_b;
  logic [1:0]         sector;
  logic signed [17:0] num;
  logic signed [17:0] den;
  logic [17:0]        num_abs;
  logic [17:0]        den_abs;
  logic               first_bit;
  logic               sub_q;

  assign a = $signed({1'b0, sample.square_x, 1'b0}) - 18'sd65536;
  assign b = $signed({1'b0, sample.square_y, 1'b0}) - 18'sd65536;
  assign sum_ab = 19'(a) + 19'(b);
  assign upper  = sum_ab > 19'sd0;
  assign a_gt_b = a > b;

  always_comb begin
    // sectors 0 and 2 divide b by a, sectors 1 and 3 divide a by b
    if (upper) begin
      sector = a_gt_b ? 2'd0 : 2'd1;
    end else begin
      sector = (a < b) ? 2'd2 : 2'd3;
    end
    num   = sector[0] ? a : b;
    den   = sector[0] ? b : a;
    sub_q = sector[0];
  end

  assign num_abs   = num[17] ? 18'(-num) : num;
  assign den_abs   = den[17] ? 18'(-den) : den;
  assign first_bit = num_abs >= den_abs;

  logic       div_valid [CSDM_DIV_STEPS+1];
  div_state_t div_state [CSDM_DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else begin
      div_valid[0] <= start && !busy;
    end
    div_state[0].rem    <= first_bit ? num_abs - den_abs : num_abs;
    div_state[0].den    <= den_abs[16:0];
    div_state[0].quo    <= {30'd0, first_bit};
    div_state[0].neg    <= num[17] ^ den[17] ^ sub_q;
    div_state[0].sector <= sector;
    // radius is |coordinate| of the one that defines the sector
    div_state[0].radius <= sector[1] ? 18'(-den) : den;
  end

  for (genvar i = 0; i < CSDM_DIV_STEPS; i++) begin : g_div
    csdm_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (div_valid[i]),
      .state_in (div_state[i]),
      .valid_out(div_valid[i+1]),
      .state_out(div_state[i+1])
    );
  end

  // ---- angle in eighth turns, split into quarter turn and residual
  div_state_t         dq;
  logic signed [33:0] quo_s;
  logic [33:0]        phi_off;
  logic               ang_valid;
  logic [1:0]         ang_quad;
  logic signed [31:0] ang_res;
  logic signed [17:0] ang_radius;

  assign dq    = div_state[CSDM_DIV_STEPS];
  assign quo_s = dq.neg ? -$signed({3'b0, dq.quo}) : $signed({3'b0, dq.quo});
  // phi + one eighth turn, always non-negative
  assign phi_off = 34'({1'b0, dq.sector, 31'd0}) + 34'd1073741824 + 34'(quo_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_valid <= 1'b0;
    end else begin
      ang_valid <= div_valid[CSDM_DIV_STEPS];
    end
    ang_quad   <= phi_off[32:31];
    ang_res    <= $signed({1'b0, phi_off[30:0]}) - 32'sd1073741824;
    ang_radius <= dq.radius;
  end

  // ---- residual to radians
  logic               rad_valid;
  logic signed [63:0] rad_prod;
  logic [1:0]         rad_quad;
  logic signed [17:0] rad_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_valid <= 1'b0;
    end else begin
      rad_valid <= ang_valid;
    end
    rad_prod   <= ang_res * CSDM_PI4;
    rad_quad   <= ang_quad;
    rad_radius <= ang_radius;
  end

  logic               cor_valid [ANGLE_ITERATIONS+1];
  cordic_state_t      cor_state [ANGLE_ITERATIONS+1];
  logic signed [63:0] rad_z;

  assign rad_z = rad_prod >>> 30;
  assign cor_valid[0]        = rad_valid;
  assign cor_state[0].x      = CSDM_GAIN_INV;
  assign cor_state[0].y      = 33'sd0;
  assign cor_state[0].z      = rad_z[32:0];
  assign cor_state[0].quad   = rad_quad;
  assign cor_state[0].radius = rad_radius;

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
    csdm_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (cor_valid[i]),
      .state_in (cor_state[i]),
      .valid_out(cor_valid[i+1]),
      .state_out(cor_state[i+1])
    );
  end

  // ---- exact quarter-turn rotation
  cordic_state_t      ce;
  logic               rot_valid;
  logic signed [32:0] rot_c;
  logic signed [32:0] rot_s;
  logic signed [17:0] rot_radius;

  assign ce = cor_state[ANGLE_ITERATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else begin
      rot_valid <= cor_valid[ANGLE_ITERATIONS];
    end
    case (ce.quad)
      2'd1: begin
        rot_c <= -ce.y;
        rot_s <= ce.x;
      end
      2'd2: begin
        rot_c <= -ce.x;
        rot_s <= -ce.y;
      end
      2'd3: begin
        rot_c <= ce.y;
        rot_s <= -ce.x;
      end
      default: begin
        rot_c <= ce.x;
        rot_s <= ce.y;
      end
    endcase
    rot_radius <= ce.radius;
  end

  // ---- scale by radius
  logic               mul_valid;
  logic signed [50:0] mul_x;
  logic signed [50:0] mul_y;
  logic               mul_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else begin
      mul_valid <= rot_valid;
    end
    mul_x    <= rot_radius * rot_c;
    mul_y    <= rot_radius * rot_s;
    mul_zero <= rot_radius == 18'sd0;
  end

  // ---- round, saturate, present for one cycle
  function automatic logic signed [15:0] round_sat(input logic signed [50:0] v);
    logic signed [50:0] rounded;
    logic signed [19:0] q;
    rounded = v + 51'sd1073741824;
    q = 20'(rounded >>> 31);
    if (q > 20'sd32767) begin
      return 16'sd32767;
    end else if (q < -20'sd32767) begin
      return -16'sd32767;
    end
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_valid;
    end
    point.disk_x <= round_sat(mul_x);
    point.disk_y <= round_sat(mul_y);
  end

  `CSDM_CHECK(a_done_from_start, done |-> $past(start, Latency), "result without started item")
  `CSDM_CHECK(a_origin_zero, $past(mul_valid && mul_zero) |-> (point == '0), "zero radius not zero")
  `CSDM_NEVER(a_no_min_x, done && point.disk_x == -16'sd32768, "disk_x beyond saturation")
  `CSDM_NEVER(a_no_min_y, done && point.disk_y == -16'sd32768, "disk_y beyond saturation")

endmodule
